// ===== rtl/fsd_pkg.sv =====
// Shared types, register indexes and constants for the flow session detector.
package fsd_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int QUEUE_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] WINDOW_MS_RST    = 16'd2000;
   localparam logic [15:0] START_PULSES_RST = 16'd10;
   localparam logic [31:0] STOP_MS_RST      = 32'd60000;
   localparam logic [31:0] SAMPLE_PUMP_RST  = 32'd10000;
   localparam logic [31:0] SAMPLE_IDLE_RST  = 32'd300000;
   localparam logic [6:0]  BATCH_MAX_RST    = 7'd10;

   typedef enum logic [2:0] {
      CSR_WINDOW_MS     = 3'd0,
      CSR_START_PULSES  = 3'd1,
      CSR_STOP_MS       = 3'd2,
      CSR_PUMP_INTERVAL = 3'd3,
      CSR_IDLE_INTERVAL = 3'd4,
      CSR_BATCH_MAX     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_HEARTBEAT = 2'd0,
      KIND_START     = 2'd1,
      KIND_READING   = 2'd2,
      KIND_END       = 2'd3
   } kind_type;

   typedef struct packed {
      logic [15:0] window_ms;
      logic [15:0] start_pulses;
      logic [31:0] stop_ms;
      logic [31:0] pump_interval;
      logic [31:0] idle_interval;
      logic [6:0]  batch_max;
   } cfg_type;

   typedef struct packed {
      logic               has_result;
      logic               session_started;
      logic               session_ended;
      logic               take_sample;
      logic [15:0]        sample_pulses;
      logic               upload_now;
      kind_type           upload_kind;
      logic [31:0]        session_number;
      logic [31:0]        total_pulses;
      logic [QUEUE_W-1:0] queued_samples;
   } result_type;

endpackage

// ===== rtl/fsd_csr.sv =====
// Configuration register file of the flow session detector.
module fsd_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output fsd_pkg::cfg_type cfg
);
   import fsd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_MS:     cfg_in.window_ms     = csr_wdata[15:0];
            CSR_START_PULSES:  cfg_in.start_pulses  = csr_wdata[15:0];
            CSR_STOP_MS:       cfg_in.stop_ms       = csr_wdata;
            CSR_PUMP_INTERVAL: cfg_in.pump_interval = csr_wdata;
            CSR_IDLE_INTERVAL: cfg_in.idle_interval = csr_wdata;
            CSR_BATCH_MAX:     cfg_in.batch_max     = csr_wdata[6:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms     <= WINDOW_MS_RST;
         cfg_ff.start_pulses  <= START_PULSES_RST;
         cfg_ff.stop_ms       <= STOP_MS_RST;
         cfg_ff.pump_interval <= SAMPLE_PUMP_RST;
         cfg_ff.idle_interval <= SAMPLE_IDLE_RST;
         cfg_ff.batch_max     <= BATCH_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/fsd_engine.sv =====
// Session state and single-pass tick evaluation of the flow session detector.
module fsd_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                op,
   input  logic [3:0]          tick_pulses,
   input  fsd_pkg::cfg_type    cfg,
   output fsd_pkg::result_type result
);
   import fsd_pkg::*;

   logic [31:0]        time_ms_ff, time_ms_in;
   logic [15:0]        window_elapsed_ff, window_elapsed_in;
   logic [15:0]        window_count_ff, window_count_in;
   logic [31:0]        pulse_total_ff, pulse_total_in;
   logic               in_session_ff, in_session_in;
   logic [31:0]        last_flow_time_ff, last_flow_time_in;
   logic [31:0]        last_sample_time_ff, last_sample_time_in;
   logic [31:0]        session_counter_ff, session_counter_in;
   kind_type           pending_kind_ff, pending_kind_in;
   logic [QUEUE_W-1:0] queue_count_ff, queue_count_in;

   function automatic logic [QUEUE_W-1:0] enqueue(input logic [QUEUE_W-1:0] q);
      if (q < QUEUE_W'(QUEUE_DEPTH)) begin
         return q + QUEUE_W'(1);
      end
      return q;
   endfunction

   logic [31:0] now;
   logic [16:0] window_sum;
   logic [15:0] window_sat;
   logic [15:0] elapsed_inc;
   logic        window_end;
   logic        ended_path;
   logic [31:0] interval;

   always_comb begin
      now         = time_ms_ff + 32'd1;
      window_sum  = {1'b0, window_count_ff} + {13'd0, tick_pulses};
      window_sat  = window_sum[16] ? 16'hFFFF : window_sum[15:0];
      elapsed_inc = (window_elapsed_ff != 16'hFFFF) ? window_elapsed_ff + 16'd1
                                                    : window_elapsed_ff;
      window_end  = (elapsed_inc >= cfg.window_ms);
      ended_path  = 1'b0;
      interval    = 32'd0;

      time_ms_in          = time_ms_ff;
      window_elapsed_in   = window_elapsed_ff;
      window_count_in     = window_count_ff;
      pulse_total_in      = pulse_total_ff;
      in_session_in       = in_session_ff;
      last_flow_time_in   = last_flow_time_ff;
      last_sample_time_in = last_sample_time_ff;
      session_counter_in  = session_counter_ff;
      pending_kind_in     = pending_kind_ff;
      queue_count_in      = queue_count_ff;

      result = '0;

      if (op) begin
         // Upload succeeded: the queue drains, nothing else moves.
         queue_count_in = '0;
      end else begin
         time_ms_in     = now;
         pulse_total_in = pulse_total_ff + {28'd0, tick_pulses};
         if (!window_end) begin
            window_count_in   = window_sat;
            window_elapsed_in = elapsed_inc;
         end else begin
            window_count_in   = '0;
            window_elapsed_in = '0;
            result.has_result = 1'b1;

            if (window_sat >= cfg.start_pulses) begin
               last_flow_time_in = now;
               if (!in_session_ff) begin
                  session_counter_in     = session_counter_ff + 32'd1;
                  in_session_in          = 1'b1;
                  pending_kind_in        = KIND_START;
                  result.session_started = 1'b1;
               end
            end else if (in_session_ff && ((now - last_flow_time_ff) > cfg.stop_ms)) begin
               // Session closes: an end sample is queued and uploaded at once.
               ended_path           = 1'b1;
               in_session_in        = 1'b0;
               queue_count_in       = enqueue(queue_count_ff);
               result.session_ended = 1'b1;
               result.take_sample   = 1'b1;
               result.upload_now    = 1'b1;
               result.upload_kind   = KIND_END;
               pending_kind_in      = KIND_HEARTBEAT;
            end

            if (!ended_path) begin
               interval = in_session_in ? cfg.pump_interval : cfg.idle_interval;
               if ((now - last_sample_time_ff) >= interval) begin
                  last_sample_time_in  = now;
                  queue_count_in       = enqueue(queue_count_ff);
                  result.take_sample   = 1'b1;
                  result.sample_pulses = window_sat;
                  if ((queue_count_in >= cfg.batch_max) || !in_session_in ||
                      (pending_kind_in == KIND_START)) begin
                     result.upload_now = 1'b1;
                     result.upload_kind = pending_kind_in;
                     pending_kind_in = in_session_in ? KIND_READING : KIND_HEARTBEAT;
                  end
               end
            end
         end
      end

      result.session_number = session_counter_in;
      result.total_pulses   = pulse_total_in;
      result.queued_samples = queue_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ms_ff          <= '0;
         window_elapsed_ff   <= '0;
         window_count_ff     <= '0;
         pulse_total_ff      <= '0;
         in_session_ff       <= 1'b0;
         last_flow_time_ff   <= '0;
         last_sample_time_ff <= '0;
         session_counter_ff  <= '0;
         pending_kind_ff     <= KIND_HEARTBEAT;
         queue_count_ff      <= '0;
      end else if (fire) begin
         time_ms_ff          <= time_ms_in;
         window_elapsed_ff   <= window_elapsed_in;
         window_count_ff     <= window_count_in;
         pulse_total_ff      <= pulse_total_in;
         in_session_ff       <= in_session_in;
         last_flow_time_ff   <= last_flow_time_in;
         last_sample_time_ff <= last_sample_time_in;
         session_counter_ff  <= session_counter_in;
         pending_kind_ff     <= pending_kind_in;
         queue_count_ff      <= queue_count_in;
      end
   end

endmodule

// ===== rtl/flow_session_detector.sv =====
// Top level of the flow session detector: input register, engine and result register.
// A result passes from the input register through the engine into the result register,
// as the engine evaluates a tick in a single pass; a waiting result holds the input stage.
// Throughput: one transaction per cycle while results are taken; mid-window ticks and
// upload-success events retire silently. Reset is synchronous and active high; it
// restores default configuration and clears session state, counters and queue count.
module flow_session_detector (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [3:0]  req_tick_pulses,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_session_started,
   output logic        rsp_session_ended,
   output logic        rsp_take_sample,
   output logic [15:0] rsp_sample_pulses,
   output logic        rsp_upload_now,
   output logic [1:0]  rsp_upload_kind,
   output logic [31:0] rsp_session_number,
   output logic [31:0] rsp_total_pulses,
   output logic [6:0]  rsp_queued_samples,

   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fsd_pkg::*;

   // Input stage: holds one accepted transaction until the engine takes it.
   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff;
   logic [3:0] in_pulses_ff;

   // Result stage: holds one result until the consumer takes it.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   cfg_type    cfg;
   result_type result;
   logic       out_free;
   logic       fire;

   // The engine advances only when the result register is empty or draining. While a
   // finished result waits, the engine holds and the input stage fills behind it.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire && result.has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff     <= req_op;
         in_pulses_ff <= req_tick_pulses;
      end
      if (fire && result.has_result) begin
         rsp_ff <= result;
      end
   end

   fsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fsd_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .op          (in_op_ff),
      .tick_pulses (in_pulses_ff),
      .cfg         (cfg),
      .result      (result)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_session_started = rsp_ff.session_started;
   assign rsp_session_ended   = rsp_ff.session_ended;
   assign rsp_take_sample     = rsp_ff.take_sample;
   assign rsp_sample_pulses   = rsp_ff.sample_pulses;
   assign rsp_upload_now      = rsp_ff.upload_now;
   assign rsp_upload_kind     = rsp_ff.upload_kind;
   assign rsp_session_number  = rsp_ff.session_number;
   assign rsp_total_pulses    = rsp_ff.total_pulses;
   assign rsp_queued_samples  = rsp_ff.queued_samples;

endmodule

// ===== dv/flow_session_detector_tb.sv =====
// Self-checking testbench for the flow session detector, with its own session predictor.
module flow_session_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsd_pkg::*;

   // Input operation codes.
   localparam logic OP_TICK      = 1'b0;
   localparam logic OP_UPLOAD_OK = 1'b1;

   // A stall that reaches this limit without any transaction ends the run.
   localparam int STALL_LIMIT   = 2000;
   // Settle margin for requests still held in the input stage after the last result.
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_REPORTED  = 10;

   // One result as the block presents it, field by field.
   typedef struct packed {
      logic        started;
      logic        ended;
      logic        sample;
      logic [15:0] sample_pulses;
      logic        upload;
      kind_type    kind;
      logic [31:0] session_no;
      logic [31:0] total;
      logic [6:0]  queued;
   } report_type;

   // The scoreboard keeps its own copy of the registers and of the session state.
   // Every accepted request transaction is run through the predictor, and each window
   // end pushes the expected report onto a queue that result transactions drain in order.
   class session_tracker_type;
      cfg_type     regs;
      logic [31:0] clock_ms;
      logic [31:0] pulse_sum;
      logic [31:0] last_flow_ms;
      logic [31:0] last_sample_ms;
      logic [31:0] sessions;
      logic [15:0] win_ticks;
      logic [15:0] win_pulses;
      logic        pumping;
      kind_type    next_kind;
      logic [6:0]  queued;
      report_type  awaited_reports[$];
      int          mismatches;
      int          checked;
      int          starts;
      int          ends;
      int          uploads;

      function new();
         regs.window_ms     = WINDOW_MS_RST;
         regs.start_pulses  = START_PULSES_RST;
         regs.stop_ms       = STOP_MS_RST;
         regs.pump_interval = SAMPLE_PUMP_RST;
         regs.idle_interval = SAMPLE_IDLE_RST;
         regs.batch_max     = BATCH_MAX_RST;
         clock_ms       = '0;
         pulse_sum      = '0;
         last_flow_ms   = '0;
         last_sample_ms = '0;
         sessions       = '0;
         win_ticks      = '0;
         win_pulses     = '0;
         pumping        = 1'b0;
         next_kind      = KIND_HEARTBEAT;
         queued         = '0;
         mismatches     = 0;
         checked        = 0;
         starts         = 0;
         ends           = 0;
         uploads        = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_WINDOW_MS:     regs.window_ms     = value[15:0];
            CSR_START_PULSES:  regs.start_pulses  = value[15:0];
            CSR_STOP_MS:       regs.stop_ms       = value;
            CSR_PUMP_INTERVAL: regs.pump_interval = value;
            CSR_IDLE_INTERVAL: regs.idle_interval = value;
            CSR_BATCH_MAX:     regs.batch_max     = value[6:0];
            default: ;
         endcase
      endfunction

      // Advances the session state by one request and queues the report, if any.
      function void absorb_request(logic op, logic [3:0] pulses);
         report_type  r;
         logic [31:0] now;
         logic [31:0] interval;
         logic [16:0] sum;
         logic [15:0] p;
         logic        closing;

         // An upload success only empties the queue; time stands still.
         if (op == OP_UPLOAD_OK) begin
            queued = '0;
            return;
         end

         clock_ms  = clock_ms + 32'd1;
         now       = clock_ms;
         pulse_sum = pulse_sum + 32'(pulses);
         sum       = {1'b0, win_pulses} + 17'(pulses);
         win_pulses = (sum > 17'h0FFFF) ? 16'hFFFF : sum[15:0];
         if (win_ticks != 16'hFFFF) begin
            win_ticks++;
         end
         if (win_ticks < regs.window_ms) begin
            return;
         end

         p          = win_pulses;
         win_pulses = '0;
         win_ticks  = '0;
         r          = '0;
         closing    = 1'b0;

         if (p >= regs.start_pulses) begin
            last_flow_ms = now;
            if (!pumping) begin
               sessions  = sessions + 32'd1;
               pumping   = 1'b1;
               next_kind = KIND_START;
               r.started = 1'b1;
            end
         end else if (pumping && (now - last_flow_ms) > regs.stop_ms) begin
            // Session closes: an end sample is queued and uploaded right away.
            pumping = 1'b0;
            if (queued < QUEUE_DEPTH) queued++;
            r.ended   = 1'b1;
            r.sample  = 1'b1;
            r.upload  = 1'b1;
            r.kind    = KIND_END;
            next_kind = KIND_HEARTBEAT;
            closing   = 1'b1;
         end

         if (!closing) begin
            interval = pumping ? regs.pump_interval : regs.idle_interval;
            if ((now - last_sample_ms) >= interval) begin
               last_sample_ms = now;
               if (queued < QUEUE_DEPTH) queued++;
               r.sample        = 1'b1;
               r.sample_pulses = p;
               if (queued >= regs.batch_max || !pumping || next_kind == KIND_START) begin
                  r.upload  = 1'b1;
                  r.kind    = next_kind;
                  next_kind = pumping ? KIND_READING : KIND_HEARTBEAT;
               end
            end
         end

         r.session_no = sessions;
         r.total      = pulse_sum;
         r.queued     = queued;
         awaited_reports.push_back(r);
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] saw);
         if (want !== saw) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
               $display("Mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
                        name, checked, want, saw);
            end
         end
      endfunction

      function void check_report(report_type seen);
         report_type want;
         if (awaited_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
               $display("Result transaction with no result expected: 0x%0h", seen);
            end
            return;
         end
         want = awaited_reports.pop_front();
         checked++;
         if (want.started) starts++;
         if (want.ended) ends++;
         if (want.upload) uploads++;
         compare("session_started", 32'(want.started), 32'(seen.started));
         compare("session_ended", 32'(want.ended), 32'(seen.ended));
         compare("take_sample", 32'(want.sample), 32'(seen.sample));
         compare("sample_pulses", 32'(want.sample_pulses), 32'(seen.sample_pulses));
         compare("upload_now", 32'(want.upload), 32'(seen.upload));
         compare("upload_kind", 32'(want.kind), 32'(seen.kind));
         compare("session_number", want.session_no, seen.session_no);
         compare("total_pulses", want.total, seen.total);
         compare("queued_samples", 32'(want.queued), 32'(seen.queued));
      endfunction

      function int outstanding();
         return awaited_reports.size();
      endfunction

      // Anything still waiting at the end never showed up.
      function void close_out();
         if (awaited_reports.size() != 0) begin
            mismatches += awaited_reports.size();
            $display("%0d expected results never arrived", awaited_reports.size());
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [3:0]  req_tick_pulses;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_session_started;
   logic        rsp_session_ended;
   logic        rsp_take_sample;
   logic [15:0] rsp_sample_pulses;
   logic        rsp_upload_now;
   logic [1:0]  rsp_upload_kind;
   logic [31:0] rsp_session_number;
   logic [31:0] rsp_total_pulses;
   logic [6:0]  rsp_queued_samples;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   session_tracker_type tracker = new();

   // When clear, both sides run without gaps so that back-to-back transactions occur.
   bit idle_on = 1'b1;
   int items_sent;
   int settings_used;

   flow_session_detector i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_tick_pulses     (req_tick_pulses),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_session_started (rsp_session_started),
      .rsp_session_ended   (rsp_session_ended),
      .rsp_take_sample     (rsp_take_sample),
      .rsp_sample_pulses   (rsp_sample_pulses),
      .rsp_upload_now      (rsp_upload_now),
      .rsp_upload_kind     (rsp_upload_kind),
      .rsp_session_number  (rsp_session_number),
      .rsp_total_pulses    (rsp_total_pulses),
      .rsp_queued_samples  (rsp_queued_samples),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Monitors sample right after the rising edge, so they see the values that the
   // handshake used at that edge; every driver update lands later in the same step.
   always @(posedge clock) begin : req_monitor
      if (!reset && req_valid && req_ready) begin
         tracker.absorb_request(req_op, req_tick_pulses);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      report_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.started       = rsp_session_started;
         seen.ended         = rsp_session_ended;
         seen.sample        = rsp_take_sample;
         seen.sample_pulses = rsp_sample_pulses;
         seen.upload        = rsp_upload_now;
         seen.kind          = kind_type'(rsp_upload_kind);
         seen.session_no    = rsp_session_number;
         seen.total         = rsp_total_pulses;
         seen.queued        = rsp_queued_samples;
         tracker.check_report(seen);
      end
   end

   // The result side draws a random stall, possibly none, for every result, then holds ready high until
   // the next result transaction completes.
   initial begin : rsp_stall
      int hold;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = idle_on ? $urandom_range(0, 14) : 0;
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // The watchdog ends the run once nothing has moved for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[flow_session_detector] ERROR");
      $finish;
   end

   // Drives one request transaction after a random gap. Valid stays high with a steady
   // payload until the block takes it; a zero gap keeps valid high for the next one.
   task automatic send_item(input logic op, input logic [3:0] pulses);
      int gap;
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_tick_pulses <= pulses;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Stops requests and waits until every expected result is in and the pipeline
   // has drained ticks that carry no result. Only then are registers touched.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all six registers, one per cycle, and mirrors them into the tracker.
   task automatic apply_settings(input cfg_type s);
      csr_index_type idx;
      logic [31:0]   value;
      idx = CSR_WINDOW_MS;
      do begin
         case (idx)
            CSR_WINDOW_MS:     value = 32'(s.window_ms);
            CSR_START_PULSES:  value = 32'(s.start_pulses);
            CSR_STOP_MS:       value = s.stop_ms;
            CSR_PUMP_INTERVAL: value = s.pump_interval;
            CSR_IDLE_INTERVAL: value = s.idle_interval;
            default:           value = 32'(s.batch_max);
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         tracker.write_reg(idx, value);
         @(posedge clock);
         idx = idx.next();
      end while (idx != CSR_WINDOW_MS);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      cfg_type plan;
      bit      flowing;
      int      run_left;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= OP_TICK;
      req_tick_pulses <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_WINDOW_MS;
      csr_wdata       <= '0;
      items_sent      = 0;
      settings_used   = 0;
      run_left        = 0;
      flowing         = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default settings: an upload success on an empty queue, quiet and full ticks,
      // and an upload success whose pulse field must be ignored. No window ends yet.
      send_item(OP_UPLOAD_OK, 4'd0);
      send_item(OP_TICK, 4'd0);
      send_item(OP_TICK, 4'hF);
      send_item(OP_UPLOAD_OK, 4'hF);
      settle();

      // One-tick windows with the smallest threshold, a zero stop time and one-tick
      // sample intervals: a session opens with a start upload, continues with a reading
      // upload, closes on the first dry tick, then idles with heartbeats. A second
      // session follows an upload success and closes again.
      plan = '{window_ms: 16'd1, start_pulses: 16'd1, stop_ms: 32'd0,
               pump_interval: 32'd1, idle_interval: 32'd1, batch_max: 7'd1};
      apply_settings(plan);
      send_item(OP_TICK, 4'hF);
      send_item(OP_TICK, 4'hF);
      send_item(OP_TICK, 4'd0);
      send_item(OP_TICK, 4'd0);
      send_item(OP_UPLOAD_OK, 4'd5);
      send_item(OP_TICK, 4'd8);
      send_item(OP_TICK, 4'd0);
      send_item(OP_TICK, 4'd0);
      settle();

      // A longer window run back to back with full ticks: the window pulse count
      // exactly meets a large threshold when the window ends.
      idle_on = 1'b0;
      plan = '{window_ms: 16'd40, start_pulses: 16'd600, stop_ms: 32'd0,
               pump_interval: 32'd1, idle_interval: 32'd1, batch_max: 7'd1};
      apply_settings(plan);
      repeat (40) send_item(OP_TICK, 4'hF);
      settle();
      idle_on = 1'b1;

      // Largest stop time and sample intervals, a batch of the queue depth: flow keeps the session
      // alive, dry windows never end it, and no sample is ever due.
      plan = '{window_ms: 16'd2, start_pulses: 16'd20, stop_ms: 32'hFFFF_FFFF,
               pump_interval: 32'hFFFF_FFFF, idle_interval: 32'hFFFF_FFFF,
               batch_max: 7'd64};
      apply_settings(plan);
      send_item(OP_TICK, 4'hF);
      send_item(OP_TICK, 4'hF);
      send_item(OP_TICK, 4'hF);
      send_item(OP_TICK, 4'd0);
      send_item(OP_TICK, 4'd0);
      send_item(OP_TICK, 4'd0);
      settle();

      // A sample every tick without any upload success: the queue fills up and sticks
      // at its depth, and from then on every sample forces an upload.
      plan = '{window_ms: 16'd1, start_pulses: 16'd1, stop_ms: 32'hFFFF_FFFF,
               pump_interval: 32'd1, idle_interval: 32'd1, batch_max: 7'd64};
      apply_settings(plan);
      repeat (70) send_item(OP_TICK, 4'($urandom_range(1, 15)));
      send_item(OP_UPLOAD_OK, 4'($urandom));
      settle();

      // Random phases. Short windows keep results frequent; traffic alternates between
      // flowing runs and dry runs so that sessions open and close, with upload
      // successes scattered in. Every fourth phase runs without any idling.
      for (int phase = 0; phase < 10; phase++) begin
         plan.window_ms = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(7, 30))
                                                       : 16'($urandom_range(1, 6));
         plan.start_pulses = 16'($urandom_range(1, 10 * int'(plan.window_ms)));
         case ($urandom_range(0, 9))
            0:       plan.stop_ms = 32'd0;
            1:       plan.stop_ms = 32'hFFFF_FFFF;
            default: plan.stop_ms = 32'($urandom_range(1, 40));
         endcase
         plan.pump_interval = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF
                                                         : 32'($urandom_range(1, 20));
         plan.idle_interval = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF
                                                         : 32'($urandom_range(1, 60));
         case ($urandom_range(0, 5))
            0:       plan.batch_max = 7'd1;
            1:       plan.batch_max = 7'd64;
            default: plan.batch_max = 7'($urandom_range(2, 20));
         endcase
         apply_settings(plan);
         idle_on = (phase % 4) != 3;

         for (int k = 0; k < 50; k++) begin
            if (run_left == 0) begin
               flowing  = 1'($urandom_range(0, 1));
               run_left = $urandom_range(3, 30);
            end
            run_left--;
            if ($urandom_range(0, 11) == 0) begin
               send_item(OP_UPLOAD_OK, 4'($urandom));
            end else if (flowing) begin
               send_item(OP_TICK, 4'($urandom));
            end else begin
               // Dry ticks carry an occasional stray pulse.
               send_item(OP_TICK, ($urandom_range(0, 7) == 0) ? 4'($urandom_range(1, 3))
                                                               : 4'd0);
            end
         end
         settle();
      end

      // The last settle has already waited out the pipeline; catch any late extras.
      repeat (SETTLE_CYCLES) @(posedge clock);
      tracker.close_out();
      $display("Covered %0d request transactions under %0d register settings.",
               items_sent, settings_used);
      $display("Checked %0d results: %0d session starts, %0d session ends, %0d uploads.",
               tracker.checked, tracker.starts, tracker.ends, tracker.uploads);
      if (tracker.mismatches == 0) begin
         $display("[flow_session_detector] OK");
      end else begin
         $display("%0d mismatches in total", tracker.mismatches);
         $display("[flow_session_detector] ERROR");
      end
      $finish;
   end

endmodule
